FILE: rtl/flfm_pkg.sv
package flfm_pkg;

	// window and ring sizes, all powers of two
	localparam int FPS_WINDOW     = 16;
	localparam int LATENCY_WINDOW = 16;
	localparam int PENDING_DEPTH  = 128;
	localparam int QUEUE_DEPTH    = 2;

	localparam int FPS_LOG     = $clog2(FPS_WINDOW);
	localparam int LAT_LOG     = $clog2(LATENCY_WINDOW);
	localparam int PEND_AW     = $clog2(PENDING_DEPTH);
	localparam int FPS_TOTAL_W = 16 + FPS_LOG;
	localparam int LAT_TOTAL_W = 16 + LAT_LOG;

	// reset values
	localparam logic [15:0] FPS_RESET      = 16'd7680;
	localparam logic [15:0] LAT_RESET      = 16'd200;
	localparam logic [15:0] INTERVAL_RESET = 16'd1000;
	localparam logic [FPS_TOTAL_W-1:0] FPS_TOTAL_RESET =
		FPS_TOTAL_W'(7680 * FPS_WINDOW);
	localparam logic [LAT_TOTAL_W-1:0] LAT_TOTAL_RESET =
		LAT_TOTAL_W'(200 * LATENCY_WINDOW);

	typedef enum logic {
		MODE_SENT     = 1'b0,
		MODE_RESPONSE = 1'b1
	} mode_t;

	// one classified word passed from front to back
	typedef struct packed {
		mode_t                 mode;
		logic [LAT_LOG-1:0]    lat_slot;
		logic [31:0]           now_ms;
		logic [15:0]           display_fps;
		logic [15:0]           measured;
	} flfm_job_t;

endpackage

FILE: rtl/flfm_ifs.sv
interface flfm_evt_if;
	logic               valid;
	logic               ready;
	flfm_pkg::mode_t    mode;
	logic [31:0]        frame_number;
	logic [31:0]        now_ms;
	logic [15:0]        display_fps;

	modport source (output valid, mode, frame_number, now_ms, display_fps, input ready);
	modport sink (input valid, mode, frame_number, now_ms, display_fps, output ready);
endinterface

interface flfm_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] average_fps;
	logic [19:0] average_latency;
	logic [15:0] measured_latency_ms;
	logic        fps_sampled;

	modport source (output valid, average_fps, average_latency, measured_latency_ms,
		fps_sampled, input ready);
	modport sink (input valid, average_fps, average_latency, measured_latency_ms,
		fps_sampled, output ready);
endinterface

FILE: rtl/flfm_ram.sv
module flfm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/flfm_front.sv
module flfm_front (
	input  logic                clk,
	input  logic                arst_n,
	flfm_evt_if.sink            evt,
	output logic                push,
	output flfm_pkg::flfm_job_t push_job,
	input  logic                queue_full
);

	import flfm_pkg::*;

	logic                 accept;
	logic                 adv_s1;
	logic [PEND_AW-1:0]   pend_addr;
	logic                 ram_we;
	logic                 ram_re;
	logic [31:0]          ram_rdata;
	logic [PENDING_DEPTH-1:0] pend_vld_q;

	logic                 valid_s1;
	mode_t                mode_s1;
	logic [LAT_LOG-1:0]   lat_slot_s1;
	logic [31:0]          now_s1;
	logic [15:0]          fps_s1;
	logic                 hit_s1;

	logic [31:0]          stored_time;
	logic [31:0]          elapsed;
	logic [15:0]          measured;

	// intake handshake
	assign adv_s1    = !valid_s1 || !queue_full;
	assign evt.ready = adv_s1;
	assign accept    = evt.valid && adv_s1;
	assign pend_addr = evt.frame_number[PEND_AW-1:0];
	assign ram_we    = accept && (evt.mode == MODE_SENT);
	assign ram_re    = accept && (evt.mode == MODE_RESPONSE);

	// send timestamp ring
	flfm_ram #(
		.WIDTH (32),
		.DEPTH (PENDING_DEPTH)
	) u_send_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pend_addr),
		.wdata (evt.now_ms),
		.re    (ram_re),
		.raddr (pend_addr),
		.rdata (ram_rdata)
	);

	// written flags, an unwritten slot reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= '0;
		end else if (ram_we) begin
			pend_vld_q[pend_addr] <= 1'b1;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= evt.valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1     <= evt.mode;
			lat_slot_s1 <= evt.frame_number[LAT_LOG-1:0];
			now_s1      <= evt.now_ms;
			fps_s1      <= evt.display_fps;
			hit_s1      <= pend_vld_q[pend_addr];
		end
	end

	// elapsed time, saturated to 16 bits; zero for frame-sent words
	always_comb begin
		stored_time = hit_s1 ? ram_rdata : 32'd0;
		elapsed     = now_s1 - stored_time;
		if (mode_s1 == MODE_SENT) begin
			measured = 16'd0;
		end else if (elapsed[31:16] != 16'd0) begin
			measured = 16'hFFFF;
		end else begin
			measured = elapsed[15:0];
		end
	end

	assign push                 = valid_s1 && !queue_full;
	assign push_job.mode        = mode_s1;
	assign push_job.lat_slot    = lat_slot_s1;
	assign push_job.now_ms      = now_s1;
	assign push_job.display_fps = fps_s1;
	assign push_job.measured    = measured;

endmodule

FILE: rtl/flfm_queue.sv
module flfm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  flfm_pkg::flfm_job_t push_job,
	output logic                full,
	output logic                head_valid,
	output flfm_pkg::flfm_job_t head_job,
	input  logic                pop
);

	import flfm_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	flfm_job_t       entry_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/flfm_back.sv
module flfm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                head_valid,
	input  flfm_pkg::flfm_job_t head_job,
	output logic                pop,
	flfm_res_if.source          res
);

	import flfm_pkg::*;

	logic [15:0]            interval_q;
	logic [15:0]            fps_hist_q [FPS_WINDOW];
	logic [FPS_LOG-1:0]     fps_slot_q;
	logic [FPS_TOTAL_W-1:0] fps_total_q;
	logic [31:0]            last_sample_q;
	logic [15:0]            lat_hist_q [LATENCY_WINDOW];
	logic [LAT_TOTAL_W-1:0] lat_total_q;

	logic                   out_vld_q;
	logic [15:0]            avg_fps_q;
	logic [19:0]            avg_lat_q;
	logic [15:0]            measured_q;
	logic                   sampled_q;

	logic [31:0]            since;
	logic                   take;
	logic                   is_resp;
	logic [FPS_TOTAL_W-1:0] fps_total_d;
	logic [LAT_TOTAL_W-1:0] lat_total_d;
	logic [LAT_TOTAL_W+3:0] lat_scaled;
	logic [FPS_TOTAL_W-1:0] fps_avg;
	logic [LAT_TOTAL_W+3:0] lat_avg;

	assign pop = head_valid && (!out_vld_q || res.ready);

	// sample decision and new running sums
	always_comb begin
		since   = head_job.now_ms - last_sample_q;
		take    = (head_job.mode == MODE_SENT) && (since >= {16'd0, interval_q});
		is_resp = (head_job.mode == MODE_RESPONSE);
		if (take) begin
			fps_total_d = fps_total_q - FPS_TOTAL_W'(fps_hist_q[fps_slot_q])
				+ FPS_TOTAL_W'(head_job.display_fps);
		end else begin
			fps_total_d = fps_total_q;
		end
		if (is_resp) begin
			lat_total_d = lat_total_q - LAT_TOTAL_W'(lat_hist_q[head_job.lat_slot])
				+ LAT_TOTAL_W'(head_job.measured);
		end else begin
			lat_total_d = lat_total_q;
		end
		fps_avg    = fps_total_d >> FPS_LOG;
		lat_scaled = {lat_total_d, 4'b0000};
		lat_avg    = lat_scaled >> LAT_LOG;
	end

	// sample interval register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			interval_q <= cfg_wdata;
		end
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FPS_WINDOW; i++) begin
				fps_hist_q[i] <= FPS_RESET;
			end
			for (int i = 0; i < LATENCY_WINDOW; i++) begin
				lat_hist_q[i] <= LAT_RESET;
			end
			fps_slot_q    <= '0;
			fps_total_q   <= FPS_TOTAL_RESET;
			last_sample_q <= '0;
			lat_total_q   <= LAT_TOTAL_RESET;
		end else if (pop) begin
			if (take) begin
				fps_hist_q[fps_slot_q] <= head_job.display_fps;
				fps_slot_q             <= fps_slot_q + 1'b1;
				last_sample_q          <= head_job.now_ms;
			end
			if (is_resp) begin
				lat_hist_q[head_job.lat_slot] <= head_job.measured;
			end
			fps_total_q <= fps_total_d;
			lat_total_q <= lat_total_d;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pop) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			avg_fps_q  <= fps_avg[15:0];
			avg_lat_q  <= lat_avg[19:0];
			measured_q <= head_job.measured;
			sampled_q  <= take;
		end
	end

	assign res.valid               = out_vld_q;
	assign res.average_fps         = avg_fps_q;
	assign res.average_latency     = avg_lat_q;
	assign res.measured_latency_ms = measured_q;
	assign res.fps_sampled         = sampled_q;

	// a sample moves the ring slot by one
	a_slot_step: assert property (@(posedge clk) disable iff (!arst_n)
		pop && take |=> fps_slot_q == FPS_LOG'($past(fps_slot_q) + 1'b1))
		else $error("fps slot did not advance on sample");

	// without a sample the fps sum and sample time hold
	a_fps_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !take |=> $stable(fps_total_q) && $stable(last_sample_q))
		else $error("fps state changed without a sample");

	// a sample records the time of its word
	a_sample_time: assert property (@(posedge clk) disable iff (!arst_n)
		pop && take |=> last_sample_q == $past(head_job.now_ms))
		else $error("sample time not recorded");

	// frame-sent words never report a latency
	a_sent_no_latency: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !is_resp |=> measured_q == 16'd0)
		else $error("latency reported for frame-sent word");

endmodule

FILE: rtl/frame_latency_fps_monitor.sv
// path: a word passes the stage-1 register, the queue and the result register before its result is offered
// throughput: one word per cycle while res.ready stays high; a stalled result register holds the queue and intake
// the send-time ring is a registered-read memory; a two-entry queue separates front and back
// reset: send-time slots read as zero, fps ring holds 30 fps, latency ring 200 ms
// reset: sample interval 1000 ms, last sample time zero; no clearing pass is needed
module frame_latency_fps_monitor (
	input  logic        clk,
	input  logic        arst_n,
	flfm_evt_if.sink    evt,
	flfm_res_if.source  res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	import flfm_pkg::*;

	logic      push;
	flfm_job_t push_job;
	logic      queue_full;
	logic      head_valid;
	flfm_job_t head_job;
	logic      pop;

	// intake, send-time ring and latency measurement
	flfm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt),
		.push       (push),
		.push_job   (push_job),
		.queue_full (queue_full)
	);

	// decoupling queue
	flfm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop)
	);

	// window sums and result register
	flfm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.res        (res)
	);

endmodule

FILE: tb/sv/testbench.sv
module testbench;
	import flfm_pkg::*;

	// one result word as the block should present it
	typedef struct {
		logic [15:0] avg_fps;
		logic [19:0] avg_lat;
		logic [15:0] measured;
		logic        sampled;
	} monitor_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	flfm_evt_if evt();
	flfm_res_if res();

	frame_latency_fps_monitor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// free-running clock, period 20
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state, mirrors the block after reset
	logic [31:0]            sent_at [PENDING_DEPTH];
	logic [15:0]            fps_ring [FPS_WINDOW];
	logic [15:0]            lat_ring [LATENCY_WINDOW];
	logic [FPS_LOG-1:0]     fps_pos;
	logic [FPS_TOTAL_W-1:0] fps_sum;
	logic [LAT_TOTAL_W-1:0] lat_sum;
	logic [31:0]            last_sample_ms;
	logic [15:0]            interval_ms;

	monitor_result_t expected_results[$];
	int unsigned     fail_count = 0;
	bit              idle_en = 1'b1;
	logic [31:0]     clock_ms;
	logic [31:0]     next_frame;

	initial begin
		for (int i = 0; i < PENDING_DEPTH; i++) sent_at[i] = '0;
		for (int i = 0; i < FPS_WINDOW; i++) fps_ring[i] = FPS_RESET;
		for (int i = 0; i < LATENCY_WINDOW; i++) lat_ring[i] = LAT_RESET;
		fps_pos = '0;
		fps_sum = FPS_TOTAL_RESET;
		lat_sum = LAT_TOTAL_RESET;
		last_sample_ms = '0;
		interval_ms = INTERVAL_RESET;
	end

	// update window sums for one accepted word and queue the result it causes
	task automatic predict_word(input mode_t m, input logic [31:0] frame,
		input logic [31:0] now, input logic [15:0] fps);
		monitor_result_t r;
		logic [31:0] since;
		logic [23:0] lat_scaled;
		r.measured = '0;
		r.sampled = 1'b0;
		if (m == MODE_SENT) begin
			since = now - last_sample_ms;
			if (since >= {16'h0, interval_ms}) begin
				fps_sum = fps_sum - fps_ring[fps_pos] + fps;
				fps_ring[fps_pos] = fps;
				fps_pos = fps_pos + 1'b1;
				last_sample_ms = now;
				r.sampled = 1'b1;
			end
			sent_at[frame[PEND_AW-1:0]] = now;
		end else begin
			since = now - sent_at[frame[PEND_AW-1:0]];
			r.measured = (since > 32'hFFFF) ? 16'hFFFF : since[15:0];
			lat_sum = lat_sum - lat_ring[frame[LAT_LOG-1:0]] + r.measured;
			lat_ring[frame[LAT_LOG-1:0]] = r.measured;
		end
		r.avg_fps = 16'(fps_sum >> FPS_LOG);
		lat_scaled = {lat_sum, 4'h0} >> LAT_LOG;
		r.avg_lat = lat_scaled[19:0];
		expected_results.push_back(r);
	endtask

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side stalls
	initial begin
		int unsigned n;
		res.ready = 1'b1;
		forever begin
			@(negedge clk);
			n = pick_gap();
			if (idle_en && n != 0 && $urandom_range(0, 2) == 0) begin
				res.ready = 1'b0;
				repeat (n) @(negedge clk);
			end
			res.ready = 1'b1;
		end
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		monitor_result_t want;
		if (arst_n && res.valid && res.ready) begin
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result word: fps %0d lat %0d meas %0d samp %0b",
						res.average_fps, res.average_latency,
						res.measured_latency_ms, res.fps_sampled);
			end else begin
				want = expected_results.pop_front();
				if (res.average_fps !== want.avg_fps ||
					res.average_latency !== want.avg_lat ||
					res.measured_latency_ms !== want.measured ||
					res.fps_sampled !== want.sampled) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"mismatch: fps exp %0d got %0d, lat exp %0d got %0d, ",
							"meas exp %0d got %0d, samp exp %0b got %0b"},
							want.avg_fps, res.average_fps, want.avg_lat,
							res.average_latency, want.measured, res.measured_latency_ms,
							want.sampled, res.fps_sampled);
				end
			end
		end
	end

	// offer one event word and hold it until taken
	task automatic send_word(input mode_t m, input logic [31:0] frame,
		input logic [31:0] now, input logic [15:0] fps);
		int unsigned gap;
		@(negedge clk);
		evt.mode = m;
		evt.frame_number = frame;
		evt.now_ms = now;
		evt.display_fps = fps;
		evt.valid = 1'b1;
		do @(posedge clk); while (!evt.ready);
		predict_word(m, frame, now, fps);
		gap = idle_en ? pick_gap() : 0;
		if (gap != 0) begin
			@(negedge clk);
			evt.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		@(negedge clk);
		evt.valid = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic set_interval(input logic [15:0] value);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		interval_ms = value;
	endtask

	// clock advance between events
	function automatic logic [31:0] pick_step();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85) return $urandom_range(0, 40);
		if (r < 95) return $urandom_range(40, 2000);
		if (r < 99) return $urandom_range(60000, 200000);
		return $urandom;
	endfunction

	// hand-picked events: fresh rings, wrap, saturation, slot sharing
	task automatic test_directed_events();
		// response with nothing sent yet reads the zero timestamp
		send_word(MODE_RESPONSE, 32'd5, 32'd100, 16'h0000);
		send_word(MODE_SENT, 32'd0, 32'd0, 16'h0000);
		send_word(MODE_SENT, 32'd1, 32'd1000, 16'hFFFF);
		send_word(MODE_SENT, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 16'h1234);
		// millisecond clock wraps between send and response
		send_word(MODE_RESPONSE, 32'hFFFF_FFFF, 32'h0000_0010, 16'hFFFF);
		// long latency saturates
		send_word(MODE_RESPONSE, 32'd1, 32'd71000, 16'h0000);
		// frame sharing a pending slot overwrites the older one
		send_word(MODE_SENT, 32'd129, 32'd2000000, 16'h5A5A);
		send_word(MODE_RESPONSE, 32'd1, 32'd2000050, 16'hA5A5);
		// same frame sent twice keeps the later time
		send_word(MODE_SENT, 32'd7, 32'd2000100, 16'h00FF);
		send_word(MODE_SENT, 32'd7, 32'd2000120, 16'hFF00);
		send_word(MODE_RESPONSE, 32'd7, 32'd2000125, 16'h0001);
		// response earlier than its send saturates
		send_word(MODE_RESPONSE, 32'd7, 32'd2000000, 16'h8000);
		send_word(MODE_SENT, 32'h8000_0000, 32'hFFFF_FFFF, 16'h7FFF);
		send_word(MODE_RESPONSE, 32'h8000_0000, 32'hFFFF_FFFF, 16'h0000);
	endtask

	// sampling threshold at its smallest and largest settings, and at one
	task automatic test_interval_extremes();
		logic [31:0] base;
		set_interval(16'h0000);
		base = last_sample_ms;
		send_word(MODE_SENT, 32'd20, base, 16'd100);
		send_word(MODE_SENT, 32'd21, base, 16'd200);
		set_interval(16'hFFFF);
		base = last_sample_ms;
		send_word(MODE_SENT, 32'd22, base + 32'd65534, 16'd300);
		send_word(MODE_SENT, 32'd23, base + 32'd65535, 16'd400);
		set_interval(16'h0001);
		base = last_sample_ms;
		send_word(MODE_SENT, 32'd24, base, 16'd500);
		send_word(MODE_SENT, 32'd25, base + 32'd1, 16'd600);
	endtask

	// send bursts answered by responses, with some stray and random words mixed in
	task automatic test_mixed_traffic(input int unsigned count);
		int unsigned issued;
		int unsigned k;
		logic [31:0] burst [8];
		logic [31:0] f;
		logic [31:0] t;
		issued = 0;
		while (issued < count) begin
			if ($urandom_range(0, 99) < 80) begin
				k = $urandom_range(1, 8);
				for (int i = 0; i < k; i++) begin
					clock_ms = clock_ms + pick_step();
					// occasionally resend the previous frame
					if (i > 0 && $urandom_range(0, 19) == 0) burst[i] = burst[i - 1];
					else begin
						burst[i] = next_frame;
						next_frame = next_frame + 1;
					end
					send_word(MODE_SENT, burst[i], clock_ms, 16'($urandom));
				end
				for (int i = 0; i < k; i++) begin
					clock_ms = clock_ms + pick_step();
					send_word(MODE_RESPONSE, burst[i], clock_ms, 16'($urandom));
				end
				issued += 2 * k;
			end else begin
				f = $urandom_range(0, 1) ? 32'($urandom)
					: next_frame - 32'($urandom_range(0, 300));
				t = ($urandom_range(0, 3) == 0) ? 32'($urandom) : clock_ms + pick_step();
				send_word(mode_t'($urandom_range(0, 1)), f, t, 16'($urandom));
				issued++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		evt.valid = 1'b0;
		evt.mode = MODE_SENT;
		evt.frame_number = '0;
		evt.now_ms = '0;
		evt.display_fps = '0;
		clock_ms = $urandom;
		next_frame = $urandom;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_events();
		test_interval_extremes();
		set_interval(INTERVAL_RESET);
		test_mixed_traffic(300);
		set_interval(16'hFFFF);
		test_mixed_traffic(200);
		set_interval(16'h0001);
		next_frame = 32'hFFFF_FF80;
		test_mixed_traffic(250);
		// back-to-back on both sides
		idle_en = 1'b0;
		set_interval(16'h0000);
		test_mixed_traffic(200);
		idle_en = 1'b1;
		set_interval(16'($urandom_range(16, 200)));
		test_mixed_traffic(300);
		set_interval(16'($urandom));
		test_mixed_traffic(250);

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#40000000;
		$display("testbench failed");
		$finish;
	end

endmodule
